FILE: hw/rtl/cal_pkg.sv
package cal_pkg;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_INC  = 2'd1;
    localparam logic [1:0] ACT_DEC  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_YEAR  = 2'd1;
    localparam logic [1:0] ST_MONTH = 2'd2;
    localparam logic [1:0] ST_DAY   = 2'd3;

    localparam logic [15:0] YEAR_MAX = 16'd65535;
    localparam logic [3:0]  MONTHS   = 4'd12;

    // Multiplicative inverse of 25 modulo 2**16 and the largest residue of a multiple of 25.
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_MAX = 16'd2621;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  load_day;
        logic [3:0]  load_month;
        logic [15:0] load_year;
    } cal_item_t;

    typedef struct packed {
        logic [4:0]  cur_day;
        logic [3:0]  cur_month;
        logic [15:0] cur_year;
        logic [4:0]  prev_day;
        logic [3:0]  prev_month;
        logic [15:0] prev_year;
        logic        leap;
        logic [4:0]  month_length;
        logic [1:0]  status;
    } cal_result_t;

    // A year is a multiple of 100 when it is a multiple of 4 and of 25, and a multiple
    // of 400 when it is a multiple of 16 and of 25.
    function automatic logic leap_of(input logic [15:0] year);
        logic [31:0] prod;
        logic        div4;
        logic        div16;
        logic        div25;
        prod  = {16'd0, year} * {16'd0, INV25};
        div4  = (year[1:0] == 2'd0);
        div16 = (year[3:0] == 4'd0);
        div25 = (prod[15:0] <= DIV25_MAX);
        return div4 && (!div25 || div16);
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2: begin
                len = leap ? 5'd29 : 5'd28;
            end
            4'd4, 4'd6, 4'd9, 4'd11: begin
                len = 5'd30;
            end
            default: begin
                len = 5'd31;
            end
        endcase
        return len;
    endfunction

endpackage

FILE: hw/rtl/calendar_date_up_down_counter_unit.sv
// Channel   Direction  Signals                     Content
// s_        in         s_tvalid s_tready s_tdata   date load or one-day step
//                      s_tuser
// m_        out        m_tvalid m_tready m_tdata   new and old date, leap, length
//                      m_tuser                     status
//
// Each transaction passes through the input register and then the result register; a new
// transaction is accepted in every cycle while the output is not stalled.
// The date state updates as an item leaves the input register, so items follow back to back.
// A stalled output holds its result and backs up into the input register only when both are full.
// Synchronous active-low reset sets the date to 1 January of year 1 and empties both stages.
module calendar_date_up_down_counter_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // load_day [4:0], load_month [8:5], load_year [24:9], zero fill [31:25]
    input  logic [31:0] s_tdata,
    // action [1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cur_day [4:0], cur_month [8:5], cur_year [24:9], prev_day [29:25],
    // prev_month [33:30], prev_year [49:34], leap [50], month_length [55:51]
    output logic [55:0] m_tdata,
    // status [1:0]
    output logic [1:0]  m_tuser
);

    cal_pkg::cal_item_t   s_item;
    cal_pkg::cal_item_t   item;
    cal_pkg::cal_result_t result;
    cal_pkg::cal_result_t m_result;
    logic                 item_valid;
    logic                 out_ready;
    logic                 advance;

    assign s_item.action     = s_tuser;
    assign s_item.load_day   = s_tdata[4:0];
    assign s_item.load_month = s_tdata[8:5];
    assign s_item.load_year  = s_tdata[24:9];

    assign advance = item_valid && out_ready;

    cal_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    cal_date_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item),
        .result  (result)
    );

    cal_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .result    (result),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (m_result)
    );

    assign m_tdata = {m_result.month_length, m_result.leap, m_result.prev_year,
                      m_result.prev_month, m_result.prev_day, m_result.cur_year,
                      m_result.cur_month, m_result.cur_day};
    assign m_tuser = m_result.status;

endmodule

FILE: hw/rtl/cal_in_reg.sv
module cal_in_reg (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  cal_pkg::cal_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output cal_pkg::cal_item_t item
);

    logic               valid_reg;
    logic               valid_next;
    cal_pkg::cal_item_t item_reg;
    logic               accept;

    assign s_tready   = !valid_reg || advance;
    assign accept     = s_tvalid && s_tready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_item;
        end
    end

endmodule

FILE: hw/rtl/cal_date_core.sv
module cal_date_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  cal_pkg::cal_item_t   item,
    output cal_pkg::cal_result_t result
);

    logic [4:0]  day_reg;
    logic [3:0]  month_reg;
    logic [15:0] year_reg;
    logic        leap_reg;

    logic [4:0]  day_next;
    logic [3:0]  month_next;
    logic [15:0] year_next;
    logic        leap_next;
    logic [1:0]  status;

    logic [4:0]  cur_len;
    logic [15:0] probe_year;
    logic        probe_leap;

    assign cur_len = cal_pkg::month_len(month_reg, leap_reg);

    always_comb begin
        case (item.action)
            cal_pkg::ACT_LOAD: begin
                probe_year = item.load_year;
            end
            cal_pkg::ACT_INC: begin
                probe_year = year_reg + 16'd1;
            end
            default: begin
                probe_year = year_reg - 16'd1;
            end
        endcase
        probe_leap = cal_pkg::leap_of(probe_year);
    end

    always_comb begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        leap_next  = leap_reg;
        status     = cal_pkg::ST_OK;
        case (item.action)
            cal_pkg::ACT_LOAD: begin
                if (item.load_year == 16'd0 || item.load_year > cal_pkg::YEAR_MAX) begin
                    status = cal_pkg::ST_YEAR;
                end else if (item.load_month == 4'd0 || item.load_month > cal_pkg::MONTHS) begin
                    status = cal_pkg::ST_MONTH;
                end else if (item.load_day == 5'd0 ||
                             item.load_day > cal_pkg::month_len(item.load_month, probe_leap)) begin
                    status = cal_pkg::ST_DAY;
                end else begin
                    day_next   = item.load_day;
                    month_next = item.load_month;
                    year_next  = item.load_year;
                    leap_next  = probe_leap;
                end
            end
            cal_pkg::ACT_INC: begin
                if (day_reg < cur_len) begin
                    day_next = day_reg + 5'd1;
                end else if (month_reg >= cal_pkg::MONTHS) begin
                    if (year_reg >= cal_pkg::YEAR_MAX) begin
                        status = cal_pkg::ST_YEAR;
                    end else begin
                        day_next   = 5'd1;
                        month_next = 4'd1;
                        year_next  = probe_year;
                        leap_next  = probe_leap;
                    end
                end else begin
                    day_next   = 5'd1;
                    month_next = month_reg + 4'd1;
                end
            end
            cal_pkg::ACT_DEC: begin
                if (day_reg > 5'd1) begin
                    day_next = day_reg - 5'd1;
                end else if (month_reg <= 4'd1) begin
                    if (year_reg <= 16'd1) begin
                        status = cal_pkg::ST_YEAR;
                    end else begin
                        month_next = cal_pkg::MONTHS;
                        year_next  = probe_year;
                        leap_next  = probe_leap;
                        day_next   = cal_pkg::month_len(cal_pkg::MONTHS, probe_leap);
                    end
                end else begin
                    month_next = month_reg - 4'd1;
                    day_next   = cal_pkg::month_len(month_reg - 4'd1, leap_reg);
                end
            end
            default: begin
                status = cal_pkg::ST_OK;
            end
        endcase
    end

    always_comb begin
        result.cur_day      = day_next;
        result.cur_month    = month_next;
        result.cur_year     = year_next;
        result.prev_day     = day_reg;
        result.prev_month   = month_reg;
        result.prev_year    = year_reg;
        result.leap         = leap_next;
        result.month_length = cal_pkg::month_len(month_next, leap_next);
        result.status       = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            day_reg   <= 5'd1;
            month_reg <= 4'd1;
            year_reg  <= 16'd1;
            leap_reg  <= 1'b0;
        end else if (advance) begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            leap_reg  <= leap_next;
        end
    end

endmodule

FILE: hw/rtl/cal_out_reg.sv
module cal_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 advance,
    input  cal_pkg::cal_result_t result,
    output logic                 out_ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output cal_pkg::cal_result_t m_result
);

    logic                 valid_reg;
    logic                 valid_next;
    cal_pkg::cal_result_t result_reg;

    assign out_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_result  = result_reg;

    always_comb begin
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

endmodule
